@@ sv/signed_decimal_field_formatter_core_defines.svh @@
// Assertion macros used by the checker file of the decimal field formatter.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_CORE_DEFINES_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sdf_pkg.sv @@
// Package with control word, status types and constants of the decimal field formatter.
package sdf_pkg;

  localparam int          PC_W       = 3;
  localparam int          ND_W       = 4;
  localparam int          MAX_DIGITS = 10;
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHR  = 35;
  localparam int          Q_W        = 64 - RECIP_SHR;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_MUL,
    OP_DIV,
    OP_SIZE,
    OP_EMIT
  } uc_op_t;

  typedef enum logic [1:0] {
    SRC_MINUS,
    SRC_PAD,
    SRC_DIGIT
  } uc_src_t;

  typedef enum logic [2:0] {
    G_ALWAYS,
    G_ZMINUS,
    G_PAD,
    G_BMINUS,
    G_DIGIT
  } uc_guard_t;

  typedef struct packed {
    uc_op_t            op;
    uc_src_t           src;
    uc_guard_t         guard;
    logic              loop;
    logic [PC_W-1:0]   tgt;
  } uc_word_t;

  typedef struct packed {
    logic in_fire;
    logic guard_ok;
    logic out_free;
    logic more;
  } sdf_stat_t;

endpackage

@@ sv/sdf_ifs.sv @@
// Input and output channel interfaces of the decimal field formatter.
interface sdf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic signed [6:0]  field_width;
  logic               force_minus;

  modport source (output valid, value, field_width, force_minus, input ready);
  modport sink   (input valid, value, field_width, force_minus, output ready);
endinterface

interface sdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;
  logic [5:0] char_count;

  modport source (output valid, character, is_last, char_count, input ready);
  modport sink   (input valid, character, is_last, char_count, output ready);
endinterface

@@ sv/sdf_rom.sv @@
// Microcode control store of the decimal field formatter.
module sdf_rom (
  input  logic [sdf_pkg::PC_W-1:0] pc,
  output sdf_pkg::uc_word_t        word
);
  import sdf_pkg::*;

  always_comb begin
    case (pc)
      3'd0:    word = '{op: OP_WAIT, src: SRC_MINUS, guard: G_ALWAYS, loop: 1'b0, tgt: 3'd0};
      3'd1:    word = '{op: OP_MUL,  src: SRC_MINUS, guard: G_ALWAYS, loop: 1'b0, tgt: 3'd0};
      3'd2:    word = '{op: OP_DIV,  src: SRC_MINUS, guard: G_ALWAYS, loop: 1'b0, tgt: 3'd1};
      3'd3:    word = '{op: OP_SIZE, src: SRC_MINUS, guard: G_ALWAYS, loop: 1'b0, tgt: 3'd0};
      3'd4:    word = '{op: OP_EMIT, src: SRC_MINUS, guard: G_ZMINUS, loop: 1'b0, tgt: 3'd0};
      3'd5:    word = '{op: OP_EMIT, src: SRC_PAD,   guard: G_PAD,    loop: 1'b1, tgt: 3'd0};
      3'd6:    word = '{op: OP_EMIT, src: SRC_MINUS, guard: G_BMINUS, loop: 1'b0, tgt: 3'd0};
      3'd7:    word = '{op: OP_EMIT, src: SRC_DIGIT, guard: G_DIGIT,  loop: 1'b1, tgt: 3'd0};
      default: word = '{op: OP_WAIT, src: SRC_MINUS, guard: G_ALWAYS, loop: 1'b0, tgt: 3'd0};
    endcase
  end

endmodule

@@ sv/sdf_sequencer.sv @@
// Step counter and next-step logic of the decimal field formatter.
module sdf_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  sdf_pkg::sdf_stat_t stat,
  output sdf_pkg::uc_word_t  ctrl
);
  import sdf_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;

  sdf_rom u_rom (
    .pc   (pc_r),
    .word (ctrl)
  );

  assign pc_inc = pc_r + PC_W'(1);

  always_comb begin
    case (ctrl.op)
      OP_WAIT: pc_nxt = stat.in_fire ? pc_inc : pc_r;
      OP_DIV:  pc_nxt = stat.more ? ctrl.tgt : pc_inc;
      OP_EMIT: begin
        if (!stat.guard_ok) begin
          pc_nxt = pc_inc;
        end else if (!stat.out_free || ctrl.loop) begin
          pc_nxt = pc_r;
        end else begin
          pc_nxt = pc_inc;
        end
      end
      default: pc_nxt = pc_inc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ sv/sdf_datapath.sv @@
// Datapath of the decimal field formatter: divider by ten, digit stack, field counters.
module sdf_datapath #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sdf_pkg::uc_word_t  ctrl,
  output sdf_pkg::sdf_stat_t stat,
  sdf_in_if.sink             in_ch,
  sdf_out_if.source          out_ch
);
  import sdf_pkg::*;

  localparam int CW = ($clog2(MAX_FIELD_WIDTH + 1) > 6) ? $clog2(MAX_FIELD_WIDTH + 1) : 6;
  localparam logic [6:0] MAXW = 7'(MAX_FIELD_WIDTH);

  logic [31:0]     mag_r;
  logic [Q_W-1:0]  q_r;
  logic            minus_r;
  logic            zf_r;
  logic [CW-1:0]   wmag_r;
  logic [ND_W-1:0] nd_r;
  logic [3:0]      stk_r [MAX_DIGITS];
  logic [CW-1:0]   pad_r;
  logic [CW-1:0]   remain_r;
  logic [CW-1:0]   total_r;
  logic            out_valid_r;
  logic [7:0]      out_char_r;
  logic            out_last_r;
  logic [5:0]      out_count_r;

  logic [31:0]   val_u;
  logic [31:0]   mag_in;
  logic [6:0]    fw_u;
  logic [6:0]    ww;
  logic [6:0]    ww_sat;
  logic [63:0]   prod;
  logic [31:0]   q10;
  logic [31:0]   rem;
  logic [CW-1:0] body;
  logic [CW-1:0] total;
  logic          guard_ok;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_char;
  logic          emit_last;

  assign val_u  = unsigned'(in_ch.value);
  assign mag_in = val_u[31] ? (32'd0 - val_u) : val_u;
  assign fw_u   = unsigned'(in_ch.field_width);
  assign ww     = fw_u[6] ? (7'd0 - fw_u) : fw_u;
  assign ww_sat = (ww > MAXW) ? MAXW : ww;

  assign prod = 64'(mag_r) * 64'(RECIP10);
  assign q10  = {q_r, 3'b000} + {2'b00, q_r, 1'b0};
  assign rem  = mag_r - q10;

  assign body  = CW'(nd_r) + CW'(minus_r);
  assign total = (body < wmag_r) ? wmag_r : body;

  always_comb begin
    case (ctrl.guard)
      G_ALWAYS: guard_ok = 1'b1;
      G_ZMINUS: guard_ok = zf_r && minus_r;
      G_PAD:    guard_ok = (pad_r != '0);
      G_BMINUS: guard_ok = !zf_r && minus_r;
      G_DIGIT:  guard_ok = (nd_r != '0);
      default:  guard_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.src)
      SRC_MINUS: emit_char = CH_MINUS;
      SRC_PAD:   emit_char = zf_r ? CH_ZERO : CH_BLANK;
      SRC_DIGIT: emit_char = CH_ZERO + {4'b0000, stk_r[0]};
      default:   emit_char = CH_BLANK;
    endcase
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit      = (ctrl.op == OP_EMIT) && guard_ok && out_free;
  assign emit_last = (remain_r == CW'(1));

  assign in_ch.ready   = (ctrl.op == OP_WAIT);
  assign stat.in_fire  = in_ch.valid && in_ch.ready;
  assign stat.guard_ok = guard_ok;
  assign stat.out_free = out_free;
  assign stat.more     = (q_r != '0) && (nd_r < ND_W'(MAX_DIGITS - 1));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.character  = out_char_r;
  assign out_ch.is_last    = out_last_r;
  assign out_ch.char_count = out_count_r;

  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      mag_r   <= mag_in;
      minus_r <= val_u[31] || in_ch.force_minus;
      zf_r    <= fw_u[6];
      wmag_r  <= CW'(ww_sat);
      nd_r    <= '0;
    end
    case (ctrl.op)
      OP_MUL: q_r <= prod[63:RECIP_SHR];
      OP_DIV: begin
        mag_r    <= 32'(q_r);
        nd_r     <= nd_r + ND_W'(1);
        stk_r[0] <= rem[3:0];
        for (int i = 1; i < MAX_DIGITS; i++) begin
          stk_r[i] <= stk_r[i-1];
        end
      end
      OP_SIZE: begin
        total_r  <= total;
        remain_r <= total;
        pad_r    <= total - body;
      end
      default: ;
    endcase
    if (emit) begin
      out_char_r  <= emit_char;
      out_last_r  <= emit_last;
      out_count_r <= emit_last ? total_r[5:0] : 6'd0;
      remain_r    <= remain_r - CW'(1);
      if (ctrl.src == SRC_PAD) begin
        pad_r <= pad_r - CW'(1);
      end
      if (ctrl.src == SRC_DIGIT) begin
        nd_r <= nd_r - ND_W'(1);
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          stk_r[i] <= stk_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

@@ sv/signed_decimal_field_formatter_core.sv @@
// Top level of the signed decimal field formatter.
// Usage:
//   in_ch takes one request: a signed 32-bit value, a signed 7-bit field width
//   (negative: zero fill, sign first; positive or zero: blank fill, sign next to
//   the digits) and a force-minus flag. out_ch returns the field as ASCII, one
//   character per transfer, leftmost first; the last one has is_last set and
//   carries the character count.
//   A small microcode program steps a shared datapath: one multiply-by-reciprocal
//   and one subtract step per decimal digit, then one emit step per character.
//   in_ch.ready is high only while the program waits for a request, so one
//   request is worked at a time; the output register lets the next request in
//   while the last character still waits.
//   When out_ch.ready is low the output register holds its character and the
//   program holds at any emit step that would overwrite it. Reset empties the
//   output register and returns the program to its wait step.
module signed_decimal_field_formatter_core #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch
);
  import sdf_pkg::*;

  uc_word_t  ctrl;
  sdf_stat_t stat;

  sdf_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  sdf_datapath #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ sv/sdf_checker.sv @@
// Port checker of the decimal field formatter and its bind to the top level.
`include "signed_decimal_field_formatter_core_defines.svh"

module sdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_is_last,
  input logic [5:0] out_char_count
);

  `SDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_character) && $stable(out_is_last), "stalled result changed")
  `SDF_ASSERT_SAME(a_count_only_last, out_valid && !out_is_last, out_char_count == 6'd0, "count on a non-final character")
  `SDF_ASSERT_SAME(a_ready_after_field, in_ready && out_valid, out_is_last, "request taken inside a field")
  `SDF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken back to back")

endmodule

bind signed_decimal_field_formatter_core sdf_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_character  (out_ch.character),
  .out_is_last    (out_ch.is_last),
  .out_char_count (out_ch.char_count)
);
